>>> rtl/core/cbe_pkg.sv
package cbe_pkg;

  // Internal curve arithmetic is signed Q.28.
  localparam int unsigned QI     = 28;
  localparam int unsigned ACC_W  = 35;          // polynomial and slope values
  localparam int unsigned T_W    = 31;          // curve parameter t, -1.0 .. 2.0
  localparam int unsigned XW     = QI + 1;      // unsigned 0 .. 1.0
  localparam int unsigned EMAG_W = ACC_W + 1;   // error value and its magnitude
  localparam int unsigned DMAG_W = ACC_W;       // slope magnitude
  localparam int unsigned Q_W    = QI + 3;      // Newton quotient bits before saturation

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [T_W-1:0]   t_t;

  localparam acc_t ONE_Q    = acc_t'(64'sd268435456);
  localparam t_t   T_MIN    = t_t'(-64'sd268435456);
  localparam t_t   T_MAX    = t_t'(64'sd536870912);
  localparam int unsigned DX_TOL   = 268;
  localparam int unsigned ERR_TOL  = 2684;
  localparam int unsigned SPAN_TOL = 27;

  // Easing mode codes; everything above ease-out is ease-in-out.
  localparam logic [2:0] FN_FLAT     = 3'd0;
  localparam logic [2:0] FN_LINEAR   = 3'd1;
  localparam logic [2:0] FN_EASE_IN  = 3'd2;
  localparam logic [2:0] FN_EASE_OUT = 3'd3;

  typedef struct packed {
    acc_t a;
    acc_t b;
    acc_t c;
  } poly_t;

  // The y curve is the same for every mode: control points 0 and 1.0.
  localparam poly_t KY = '{a: acc_t'(-64'sd536870912), b: acc_t'(64'sd805306368),
                           c: acc_t'(64'sd0)};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SLOPE,
    ST_SCHK,
    ST_NPOLY,
    ST_NCHK,
    ST_DIV,
    ST_BTEST,
    ST_BPOLY,
    ST_BCHK,
    ST_YPOLY,
    ST_YOUT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic done;
    logic sat;
  } div_stat_t;

  // Coefficients of the x curve for a mode.
  function automatic poly_t get_poly(input logic [2:0] mode);
    poly_t r;
    unique case (mode)
      FN_EASE_IN: begin
        r = '{a: acc_t'(-64'sd198642236), b: acc_t'(64'sd128849016),
              c: acc_t'(64'sd338228676)};
      end
      FN_EASE_OUT: begin
        r = '{a: acc_t'(-64'sd198642236), b: acc_t'(64'sd467077692),
              c: acc_t'(64'sd0)};
      end
      default: begin
        r = '{a: acc_t'(64'sd139586440), b: acc_t'(-64'sd209379660),
              c: acc_t'(64'sd338228676)};
      end
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/cbe_in_if.sv
interface cbe_in_if #(
  parameter int unsigned PROG_W = 19
);
  logic                     valid;
  logic                     ready;
  logic [2:0]               func;
  logic signed [PROG_W-1:0] progress;

  modport source (output valid, output func, output progress, input ready);
  modport sink (input valid, input func, input progress, output ready);
endinterface

>>> rtl/core/cbe_out_if.sv
interface cbe_out_if #(
  parameter int unsigned EASED_W = 17
);
  logic               valid;
  logic               ready;
  logic [EASED_W-1:0] eased;

  modport source (output valid, output eased, input ready);
  modport sink (input valid, input eased, output ready);
endinterface

>>> rtl/core/cbe_mulq.sv
module cbe_mulq
  import cbe_pkg::*;
(
  input  acc_t op_a_i,
  input  t_t   op_t_i,
  input  acc_t addend_i,
  output acc_t res_o
);

  logic [ACC_W-2:0]     mag_a;
  logic [T_W-2:0]       mag_t;
  logic [ACC_W+T_W-3:0] prod;
  logic [ACC_W+T_W-3:0] rnd;
  acc_t                 prod_q;

  // Sign-magnitude product, rounded half away from zero to Q.28.
  assign mag_a  = op_a_i[ACC_W-1] ? (ACC_W-1)'(-op_a_i) : op_a_i[ACC_W-2:0];
  assign mag_t  = op_t_i[T_W-1] ? (T_W-1)'(-op_t_i) : op_t_i[T_W-2:0];
  assign prod   = mag_a * mag_t;
  assign rnd    = (prod + (ACC_W+T_W-2)'(64'd1 << (QI - 1))) >> QI;
  assign prod_q = (op_a_i[ACC_W-1] ^ op_t_i[T_W-1]) ? -acc_t'(rnd) : acc_t'(rnd);
  assign res_o  = prod_q + addend_i;

endmodule

>>> rtl/core/cbe_div.sv
module cbe_div
  import cbe_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [EMAG_W-1:0] num_i,
  input  logic [DMAG_W-1:0] den_i,
  output logic [Q_W-1:0]    quot_o,
  output div_stat_t         stat_o
);

  localparam int unsigned CNT_W = $clog2(Q_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              sat_q, sat_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DMAG_W-1:0] rem_q, rem_d;
  logic [DMAG_W-1:0] den_q, den_d;
  logic [Q_W-1:0]    nbits_q, nbits_d;
  logic [Q_W-1:0]    quot_q, quot_d;
  logic [DMAG_W:0]   trial;
  logic              fits;

  // One quotient bit a cycle; the numerator is the error shifted up by QI.
  assign trial = {rem_q, nbits_q[Q_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    sat_d   = sat_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    nbits_d = nbits_q;
    quot_d  = quot_q;
    if (start_i) begin
      busy_d  = 1'b1;
      sat_d   = {2'b0, num_i} >= {den_i, 3'b000};
      cnt_d   = CNT_W'(Q_W);
      rem_d   = DMAG_W'(num_i >> 3);
      den_d   = den_i;
      nbits_d = {num_i[2:0], QI'(0)};
      quot_d  = '0;
    end else if (busy_q) begin
      rem_d   = fits ? DMAG_W'(trial - {1'b0, den_q}) : trial[DMAG_W-1:0];
      quot_d  = {quot_q[Q_W-2:0], fits};
      nbits_d = {nbits_q[Q_W-2:0], 1'b0};
      cnt_d   = cnt_q - 1'b1;
      if (sat_q || cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q   <= sat_d;
    cnt_q   <= cnt_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
    nbits_q <= nbits_d;
    quot_q  <= quot_d;
  end

  assign quot_o = quot_q;
  assign stat_o = '{done: done_q, sat: sat_q};

endmodule

>>> rtl/core/cubic_bezier_easing.sv
// Channel  Direction  Payload
// in_i     sink       func (3 bits), progress (FRAC_BITS+3 bits, signed)
// out_o    source     eased (FRAC_BITS+1 bits)
//
// Flat and linear requests are answered without the curve arithmetic. Each Newton step
// of a curve mode evaluates the slope and x(t), then runs the one-bit-a-cycle divider
// (Q.28 quotient, 31 bits); each bisection step evaluates x(t), and a final y evaluation gives the result;
// all multiplies share one rounding multiplier. One request is in work at a time.
// Reset clears the sequencer and the output valid. A waiting result does not block
// the next request, but it is held until the sink takes it before another is shown.
module cubic_bezier_easing
  import cbe_pkg::*;
#(
  parameter int unsigned FRAC_BITS    = 16,
  parameter int unsigned NEWTON_STEPS = 8,
  parameter int unsigned BISECT_STEPS = 30
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cbe_in_if.sink    in_i,
  cbe_out_if.source out_o
);

  localparam int unsigned EW   = FRAC_BITS + 1;
  localparam int unsigned PW   = FRAC_BITS + 3;
  localparam int unsigned SH   = QI - FRAC_BITS;
  localparam int unsigned NI_W = $clog2(NEWTON_STEPS + 1);
  localparam int unsigned BI_W = $clog2(BISECT_STEPS + 1);
  localparam logic [EW-1:0] ONE_OUT = EW'(1) << FRAC_BITS;

  state_e            state_q, state_d;
  logic [1:0]        k_q, k_d;
  logic [2:0]        mode_q, mode_d;
  logic [XW-1:0]     x_q, x_d;
  t_t                t_q, t_d;
  acc_t              acc_q, acc_d;
  acc_t              dv_q, dv_d;
  logic [XW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [NI_W-1:0]   ni_q, ni_d;
  logic [BI_W-1:0]   bi_q, bi_d;
  logic              qneg_q, qneg_d;
  logic [EW-1:0]     res_q, res_d;
  logic [EW-1:0]     eased_q, eased_d;
  logic              ovalid_q, ovalid_d;

  poly_t             cur_k;
  acc_t              mul_a, mul_add, mul_res;
  logic              slope_ph;
  logic [1:0]        last_k;
  logic signed [EMAG_W-1:0] err_w;
  logic [EMAG_W-1:0] err_mag;
  logic [DMAG_W-1:0] acc_mag, dv_mag;
  logic              div_start;
  logic [Q_W-1:0]    quot;
  div_stat_t         div_stat;
  logic signed [T_W+2:0] t_new;
  logic [EW-1:0]     p_clamp;
  logic [ACC_W-1:0]  y_sum, y_shr;
  logic [XW:0]       mid_sum;

  // Shared rounding multiplier and serial divider.
  cbe_mulq u_mulq (
    .op_a_i   (mul_a),
    .op_t_i   (t_q),
    .addend_i (mul_add),
    .res_o    (mul_res)
  );

  cbe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (err_mag),
    .den_i   (dv_mag),
    .quot_o  (quot),
    .stat_o  (div_stat)
  );

  // Operand selection for Horner steps of x(t), y(t) and the slope.
  always_comb begin
    cur_k    = (state_q == ST_YPOLY) ? KY : get_poly(mode_q);
    slope_ph = (state_q == ST_SLOPE);
    last_k   = slope_ph ? 2'd1 : 2'd2;
    if (k_q == 2'd0) begin
      mul_a   = slope_ph ? cur_k.a + (cur_k.a <<< 1) : cur_k.a;
      mul_add = slope_ph ? (cur_k.b <<< 1) : cur_k.b;
    end else if (k_q == 2'd1) begin
      mul_a   = acc_q;
      mul_add = cur_k.c;
    end else begin
      mul_a   = acc_q;
      mul_add = '0;
    end
  end

  // Error against the target, magnitudes and helpers.
  always_comb begin
    err_w   = EMAG_W'(acc_q) - $signed({(EMAG_W-XW)'(0), x_q});
    err_mag = err_w[EMAG_W-1] ? EMAG_W'(-err_w) : EMAG_W'(err_w);
    acc_mag = acc_q[ACC_W-1] ? DMAG_W'(-acc_q) : DMAG_W'(acc_q);
    dv_mag  = dv_q[ACC_W-1] ? DMAG_W'(-dv_q) : DMAG_W'(dv_q);
    t_new   = qneg_q ? (T_W+3)'(t_q) + $signed({3'b000, quot})
                     : (T_W+3)'(t_q) - $signed({3'b000, quot});
    if (in_i.progress[PW-1]) begin
      p_clamp = '0;
    end else if (in_i.progress[PW-2:0] > (PW-1)'(ONE_OUT)) begin
      p_clamp = ONE_OUT;
    end else begin
      p_clamp = EW'(in_i.progress[PW-2:0]);
    end
    y_sum = acc_q[ACC_W-1] ? ACC_W'(1 << (SH - 1))
                           : {1'b0, acc_q[ACC_W-2:0]} + ACC_W'(1 << (SH - 1));
    y_shr = y_sum >> SH;
  end

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    mode_d    = mode_q;
    x_d       = x_q;
    t_d       = t_q;
    acc_d     = acc_q;
    dv_d      = dv_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    ni_d      = ni_q;
    bi_d      = bi_q;
    qneg_d    = qneg_q;
    res_d     = res_q;
    eased_d   = eased_q;
    ovalid_d  = ovalid_q & ~out_o.ready;
    div_start = 1'b0;
    mid_sum   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          mode_d = in_i.func;
          x_d    = {p_clamp, SH'(0)};
          t_d    = t_t'({p_clamp, SH'(0)});
          ni_d   = '0;
          k_d    = '0;
          if (in_i.func == FN_FLAT) begin
            res_d   = '0;
            state_d = ST_DONE;
          end else if (in_i.func == FN_LINEAR) begin
            res_d   = p_clamp;
            state_d = ST_DONE;
          end else begin
            state_d = ST_SLOPE;
          end
        end
      end
      ST_SLOPE, ST_NPOLY, ST_BPOLY, ST_YPOLY: begin
        acc_d = mul_res;
        if (k_q == last_k) begin
          k_d = '0;
          priority case (state_q)
            ST_SLOPE: state_d = ST_SCHK;
            ST_NPOLY: state_d = ST_NCHK;
            ST_BPOLY: state_d = ST_BCHK;
            default:  state_d = ST_YOUT;
          endcase
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      ST_SCHK: begin
        dv_d = acc_q;
        if (acc_mag < DMAG_W'(DX_TOL)) begin
          lo_d    = '0;
          hi_d    = XW'(ONE_Q);
          t_d     = t_t'(x_q);
          bi_d    = '0;
          state_d = ST_BTEST;
        end else begin
          state_d = ST_NPOLY;
        end
      end
      ST_NCHK: begin
        if (err_mag < EMAG_W'(ERR_TOL)) begin
          state_d = ST_YPOLY;
        end else begin
          qneg_d    = err_w[EMAG_W-1] ^ dv_q[ACC_W-1];
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (div_stat.sat) begin
            t_d = qneg_q ? T_MAX : T_MIN;
          end else if (t_new < (T_W+3)'(T_MIN)) begin
            t_d = T_MIN;
          end else if (t_new > (T_W+3)'(T_MAX)) begin
            t_d = T_MAX;
          end else begin
            t_d = T_W'(t_new);
          end
          ni_d = ni_q + 1'b1;
          if (ni_q + 1'b1 == NI_W'(NEWTON_STEPS)) begin
            lo_d    = '0;
            hi_d    = XW'(ONE_Q);
            t_d     = t_t'(x_q);
            bi_d    = '0;
            state_d = ST_BTEST;
          end else begin
            state_d = ST_SLOPE;
          end
        end
      end
      ST_BTEST: begin
        if (bi_q < BI_W'(BISECT_STEPS) && (hi_q - lo_q) > XW'(SPAN_TOL)) begin
          state_d = ST_BPOLY;
        end else begin
          state_d = ST_YPOLY;
        end
      end
      ST_BCHK: begin
        if (err_mag < EMAG_W'(ERR_TOL)) begin
          state_d = ST_YPOLY;
        end else begin
          if (!err_w[EMAG_W-1] && err_w != '0) begin
            hi_d    = XW'(t_q);
            mid_sum = {1'b0, lo_q} + {1'b0, XW'(t_q)};
          end else begin
            lo_d    = XW'(t_q);
            mid_sum = {1'b0, XW'(t_q)} + {1'b0, hi_q};
          end
          t_d     = t_t'(mid_sum[XW:1]);
          bi_d    = bi_q + 1'b1;
          state_d = ST_BTEST;
        end
      end
      ST_YOUT: begin
        res_d   = (y_shr > ACC_W'(ONE_OUT)) ? ONE_OUT : EW'(y_shr);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          eased_d  = res_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      k_q      <= '0;
      ni_q     <= '0;
      bi_q     <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      ni_q     <= ni_d;
      bi_q     <= bi_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    x_q     <= x_d;
    t_q     <= t_d;
    acc_q   <= acc_d;
    dv_q    <= dv_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    qneg_q  <= qneg_d;
    res_q   <= res_d;
    eased_q <= eased_d;
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = ovalid_q;
  assign out_o.eased = eased_q;

endmodule
